// ===== sv/assert_macros.svh =====
// assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define SBT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define SBT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== sv/sbt_pkg.sv =====
// package: types, constants and gain table functions of the band-pass taper
`default_nettype none
package sbt_pkg;

	localparam int MAX_BINS_DEF       = 8192;
	localparam int COS_TABLE_BITS_DEF = 10;
	localparam int SAMPLE_BITS_DEF    = 24;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 33;
	localparam int GAIN_W     = 17;
	localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

	localparam logic [31:0] RST_SAMPLE_RATE = 32'd12288000;
	localparam logic [14:0] RST_FFT_POINTS  = 15'd1024;
	localparam logic [31:0] RST_LOW_EDGE    = 32'd76800;
	localparam logic [31:0] RST_HIGH_EDGE   = 32'd870400;
	localparam logic [32:0] RST_TRANS_WIDTH = 33'h1FFFFFFFF;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_SAMPLE_RATE = 3'd0,
		REG_FFT_POINTS  = 3'd1,
		REG_LOW_EDGE    = 3'd2,
		REG_HIGH_EDGE   = 3'd3,
		REG_TRANS_WIDTH = 3'd4
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_START,
		ST_SETUP_DIV,
		ST_SETUP,
		ST_CLASSIFY,
		ST_GAIN_DIV,
		ST_LOOKUP,
		ST_MUL,
		ST_ROUND
	} state_t;

	typedef struct packed {
		logic load;
		logic setup_div;
		logic setup;
		logic step_freq;
		logic classify;
		logic gain_div;
		logic rom_rd;
		logic rom_gain;
		logic mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic first_item;
		logic ramp;
		logic div_done;
		logic out_free;
	} status_t;

	localparam longint unsigned PI_Q30  = 64'd3373259426;
	localparam longint unsigned ONE_Q30 = 64'd1073741824;

	// taylor term denominators (2n-1)*(2n)
	localparam longint unsigned TAYLOR_DEN [1:10] = '{
		64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
		64'd132, 64'd182, 64'd240, 64'd306, 64'd380
	};

	function automatic longint unsigned cos_q30(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		x2 = (x * x) >> 30;
		term = ONE_Q30;
		sum = longint'(ONE_Q30);
		for (int n = 1; n <= 10; n++) begin
			term = term * x2 / TAYLOR_DEN[n];
			if (n[0]) sum = sum - longint'(term);
			else sum = sum + longint'(term);
		end
		if (sum < 0) sum = 0;
		if (sum > longint'(ONE_Q30)) sum = longint'(ONE_Q30);
		return longint'(sum);
	endfunction

	function automatic logic [GAIN_W-1:0] gain_entry(input int i, input int bits);
		int half;
		int size;
		int j;
		longint unsigned x;
		longint unsigned c;
		longint unsigned v;
		size = 1 << bits;
		half = size >> 1;
		j = (i <= half) ? i : size - i;
		x = (PI_Q30 * longint'(j)) >> bits;
		c = cos_q30(x);
		v = (ONE_Q30 - c + 64'd16384) >> 15;
		if (i > half) v = 64'd65536 - v;
		return v[GAIN_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/sbt_div.sv =====
// restoring divider, one quotient bit per cycle, 32-bit divisor
`default_nettype none
module sbt_div #(
	parameter int DW = 42
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [31:0]   divisor,
	output logic      [DW-1:0] quot,
	output logic               done
);
	localparam int CW = $clog2(DW + 1);

	logic [31:0]   rem_q;
	logic [DW-1:0] quot_q;
	logic [31:0]   div_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   trial;
	logic          take;

	assign trial = {rem_q, quot_q[DW-1]};
	assign take  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quot_q <= dividend;
			div_q  <= divisor;
		end else if (busy_q) begin
			rem_q  <= take ? 32'(trial - {1'b0, div_q}) : trial[31:0];
			quot_q <= {quot_q[DW-2:0], take};
		end
	end

	assign quot = quot_q;
	assign done = done_q;
endmodule
`default_nettype wire

// ===== sv/sbt_ctrl.sv =====
// controller state machine sequencing setup, gain and output of one bin
`default_nettype none
module sbt_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_ready,
	input  wire sbt_pkg::status_t sts,
	output sbt_pkg::cmd_t        cmd
);
	import sbt_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (sts.first_item) begin
					cmd.setup_div = 1'b1;
					state_d       = ST_SETUP_DIV;
				end else begin
					cmd.step_freq = 1'b1;
					state_d       = ST_CLASSIFY;
				end
			end
			ST_SETUP_DIV: begin
				if (sts.div_done) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_MUL;
			end
			ST_CLASSIFY: begin
				cmd.classify = 1'b1;
				if (sts.ramp) begin
					cmd.gain_div = 1'b1;
					state_d      = ST_GAIN_DIV;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_GAIN_DIV: begin
				if (sts.div_done) begin
					cmd.rom_rd = 1'b1;
					state_d    = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				cmd.rom_gain = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_ROUND;
			end
			ST_ROUND: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== sv/sbt_dp.sv =====
// datapath: registers, bin frequency, transition width, gain lookup and scaling
`default_nettype none
module sbt_dp #(
	parameter int MAX_BINS       = sbt_pkg::MAX_BINS_DEF,
	parameter int COS_TABLE_BITS = sbt_pkg::COS_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS    = sbt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [sbt_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  wire logic [sbt_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic signed [SAMPLE_BITS-1:0]   bin_real,
	input  wire logic signed [SAMPLE_BITS-1:0]   bin_imag,
	input  wire logic                            last_bin,
	output logic                                 out_valid,
	input  wire logic                            out_ready,
	output logic signed [SAMPLE_BITS-1:0]        out_real,
	output logic signed [SAMPLE_BITS-1:0]        out_imag,
	output logic                                 out_last,
	input  wire sbt_pkg::cmd_t                   cmd,
	output sbt_pkg::status_t                     sts
);
	import sbt_pkg::*;

	localparam int BIW   = $clog2(MAX_BINS);
	localparam int TSIZE = 1 << COS_TABLE_BITS;
	localparam int IDXW  = COS_TABLE_BITS + 1;
	localparam int DW    = 32 + COS_TABLE_BITS;
	localparam int PW    = SAMPLE_BITS + GAIN_W + 1;

	typedef logic [GAIN_W-1:0] rom_t [0:TSIZE];

	function automatic rom_t build_rom();
		rom_t r;
		for (int i = 0; i <= TSIZE; i++) r[i] = gain_entry(i, COS_TABLE_BITS);
		return r;
	endfunction

	localparam rom_t GAIN_ROM = build_rom();

	function automatic logic [SAMPLE_BITS-1:0] round_gain(input logic signed [PW-1:0] p);
		logic [PW-1:0] mag;
		logic [PW-1:0] r;
		mag = p[PW-1] ? PW'(-p) : PW'(p);
		r = (mag + PW'(32768)) >> 16;
		if (p[PW-1]) r = PW'(-r);
		return r[SAMPLE_BITS-1:0];
	endfunction

	logic [31:0] sample_rate_q;
	logic [14:0] fft_points_q;
	logic [31:0] low_edge_q;
	logic [31:0] high_edge_q;
	logic [32:0] trans_width_q;

	logic [BIW-1:0] bin_index_q;
	logic [31:0]    freq_q;
	logic [31:0]    df_q;
	logic [31:0]    ew_q;

	logic signed [SAMPLE_BITS-1:0] re_q;
	logic signed [SAMPLE_BITS-1:0] im_q;
	logic last_q;
	logic first_q;
	logic fall_q;
	logic [GAIN_W-1:0] g_q;
	logic [GAIN_W-1:0] rom_q;
	logic signed [PW-1:0] prod_re_s1;
	logic signed [PW-1:0] prod_im_s1;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_rate_q <= RST_SAMPLE_RATE;
			fft_points_q  <= RST_FFT_POINTS;
			low_edge_q    <= RST_LOW_EDGE;
			high_edge_q   <= RST_HIGH_EDGE;
			trans_width_q <= RST_TRANS_WIDTH;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SAMPLE_RATE: sample_rate_q <= cfg_data[31:0];
				REG_FFT_POINTS:  fft_points_q  <= cfg_data[14:0];
				REG_LOW_EDGE:    low_edge_q    <= cfg_data[31:0];
				REG_HIGH_EDGE:   high_edge_q   <= cfg_data[31:0];
				REG_TRANS_WIDTH: trans_width_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider shared by setup and gain index
	logic [DW-1:0] div_num;
	logic [31:0]   div_den;
	logic [DW-1:0] quot;
	logic          div_done;
	logic [14:0]   n_eff;

	// band classification
	logic signed [33:0] start_s;
	logic signed [33:0] f_s;
	logic below;
	logic rising;
	logic flat;
	logic falling;
	logic [31:0] num;

	assign n_eff   = (fft_points_q == 15'd0) ? 15'd1 : fft_points_q;
	assign start_s = $signed({2'b0, low_edge_q}) - $signed({2'b0, ew_q});
	assign f_s     = $signed({2'b0, freq_q});
	assign below   = f_s < start_s;
	assign rising  = !below && (freq_q < low_edge_q);
	assign flat    = (freq_q >= low_edge_q) && (freq_q <= high_edge_q);
	assign falling = (freq_q >= low_edge_q) && (freq_q > high_edge_q) &&
		({1'b0, freq_q} <= ({1'b0, high_edge_q} + {1'b0, ew_q}));
	assign num     = rising ? 32'(f_s - start_s) : (freq_q - high_edge_q);

	assign div_num = cmd.setup_div ? {{COS_TABLE_BITS{1'b0}}, sample_rate_q}
		: {num, {COS_TABLE_BITS{1'b0}}};
	assign div_den = cmd.setup_div ? {17'd0, n_eff} : ew_q;

	sbt_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.setup_div | cmd.gain_div),
		.dividend (div_num),
		.divisor  (div_den),
		.quot     (quot),
		.done     (div_done)
	);

	// effective transition width
	logic [31:0] df_new;
	logic [35:0] tw0;
	logic [31:0] tw1;
	logic [33:0] sum2;
	logic signed [33:0] dlt;
	logic [31:0] tw2;
	logic [31:0] tw3;

	assign df_new = quot[31:0];
	assign tw0  = trans_width_q[32] ? ({4'd0, df_new} << 3) + ({4'd0, df_new} << 1)
		: {3'd0, trans_width_q};
	assign tw1  = (tw0 > {4'd0, low_edge_q}) ? low_edge_q : tw0[31:0];
	assign sum2 = ({2'b0, high_edge_q} + {2'b0, tw1}) << 1;
	assign dlt  = $signed({2'b0, sample_rate_q}) - $signed({1'b0, high_edge_q, 1'b0});
	assign tw2  = (sum2 > {2'b0, sample_rate_q}) ? (dlt[33] ? 32'd0 : dlt[32:1]) : tw1;
	assign tw3  = (tw2 == 32'd0) ? 32'd1 : tw2;

	// table address from quotient
	logic [IDXW-1:0] idx;
	logic [IDXW-1:0] addr;

	assign idx  = (quot > DW'(TSIZE)) ? IDXW'(TSIZE) : quot[IDXW-1:0];
	assign addr = fall_q ? IDXW'(TSIZE) - idx : idx;

	logic [32:0] f_next;
	assign f_next = {1'b0, freq_q} + {1'b0, df_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_index_q <= '0;
			freq_q      <= '0;
			df_q        <= '0;
			ew_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (last_bin) bin_index_q <= '0;
				else if (bin_index_q != BIW'(MAX_BINS - 1)) bin_index_q <= bin_index_q + 1'b1;
			end
			if (cmd.setup) begin
				df_q   <= df_new;
				ew_q   <= tw3;
				freq_q <= '0;
			end
			if (cmd.step_freq) freq_q <= f_next[32] ? 32'hFFFFFFFF : f_next[31:0];
			if (cmd.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			re_q    <= bin_real;
			im_q    <= bin_imag;
			last_q  <= last_bin;
			first_q <= (bin_index_q == '0);
		end
		if (cmd.setup) g_q <= GAIN_ONE;
		if (cmd.classify) begin
			g_q    <= flat ? GAIN_ONE : '0;
			fall_q <= falling;
		end
		if (cmd.rom_rd) rom_q <= GAIN_ROM[addr];
		if (cmd.rom_gain) g_q <= rom_q;
		if (cmd.mul) begin
			prod_re_s1 <= PW'(re_q) * $signed({1'b0, g_q});
			prod_im_s1 <= PW'(im_q) * $signed({1'b0, g_q});
		end
		if (cmd.out_load) begin
			out_real <= round_gain(prod_re_s1);
			out_imag <= (last_q && !first_q) ? '0 : round_gain(prod_im_s1);
			out_last <= last_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign sts.first_item = first_q;
	assign sts.ramp       = rising || falling;
	assign sts.div_done   = div_done;
	assign sts.out_free   = !out_valid_q || out_ready;
endmodule
`default_nettype wire

// ===== sv/spectral_bandpass_taper.sv =====
// top level: band-pass raised-cosine mask over a streamed spectrum
// a bin in a flat or stop band skips the divider; a bin on a transition ramp and the first
// bin of a spectrum each wait for a division by the shared divider before the multiply
// throughput: one bin at a time; the restoring divider gives one bit per cycle
// an output register lets the next bin enter while a result waits
// reset: registers take their defaults, bin position, frequency and width clear
`default_nettype none
module spectral_bandpass_taper #(
	parameter int MAX_BINS       = sbt_pkg::MAX_BINS_DEF,
	parameter int COS_TABLE_BITS = sbt_pkg::COS_TABLE_BITS_DEF,
	parameter int SAMPLE_BITS    = sbt_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [sbt_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [sbt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic signed [SAMPLE_BITS-1:0]  bin_real,
	input  wire logic signed [SAMPLE_BITS-1:0]  bin_imag,
	input  wire logic                           last_bin,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic signed [SAMPLE_BITS-1:0]       out_real,
	output logic signed [SAMPLE_BITS-1:0]       out_imag,
	output logic                                out_last
);
	import sbt_pkg::*;

	cmd_t    cmd;
	status_t sts;

	sbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	sbt_dp #(
		.MAX_BINS       (MAX_BINS),
		.COS_TABLE_BITS (COS_TABLE_BITS),
		.SAMPLE_BITS    (SAMPLE_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.bin_real  (bin_real),
		.bin_imag  (bin_imag),
		.last_bin  (last_bin),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_real  (out_real),
		.out_imag  (out_imag),
		.out_last  (out_last),
		.cmd       (cmd),
		.sts       (sts)
	);
endmodule
`default_nettype wire

// ===== sv/sbt_checker.sv =====
// port-level checker for the band-pass taper and its bind
`default_nettype none
`include "assert_macros.svh"
module sbt_checker #(
	parameter int SAMPLE_BITS = sbt_pkg::SAMPLE_BITS_DEF
) (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_valid,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic signed [SAMPLE_BITS-1:0]  out_imag,
	input wire logic                           out_last
);
	logic [1:0] pend_q;
	logic       out_first_q;
	logic       in_beat;
	logic       out_beat;

	assign in_beat  = in_valid && in_ready;
	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= '0;
			out_first_q <= 1'b1;
		end else begin
			pend_q <= pend_q + {1'b0, in_beat} - {1'b0, out_beat};
			if (out_beat) out_first_q <= out_last;
		end
	end

	`SBT_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	`SBT_ASSERT_IMP(a_no_extra_beat, clk, arst_n, out_valid, pend_q != 2'd0)
	`SBT_ASSERT_IMP(a_pend_bound, clk, arst_n, 1'b1, pend_q != 2'd3)
	`SBT_ASSERT_IMP(a_last_imag_zero, clk, arst_n, out_valid && out_last && !out_first_q,
		out_imag == '0)
endmodule

bind spectral_bandpass_taper sbt_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_sbt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_imag  (out_imag),
	.out_last  (out_last)
);
`default_nettype wire
